// ===== rtl/sweif_pkg.sv =====
// Shared types, codes and constants for the safety watchdog interlock.
// Used by every module of the block; depends on nothing.
package sweif_pkg;

	localparam int MS_PER_SECOND = 1000;
	localparam int MS_PER_TENTH  = 100;

	localparam int WD_W  = 18;
	localparam int EM_W  = 15;
	localparam int CM_W  = 15;
	localparam int CFG_W = 8;
	localparam int IDX_W = 2;

	localparam logic [CFG_W-1:0] WD_RESET_SECONDS = 8'd5;
	localparam logic [CFG_W-1:0] EM_RESET_TENTHS  = 8'd20;
	localparam logic [CFG_W-1:0] CM_RESET_TENTHS  = 8'd20;

	localparam logic [IDX_W-1:0] CFG_WATCHDOG_SECONDS  = 2'd0;
	localparam logic [IDX_W-1:0] CFG_EMERGENCY_TENTHS  = 2'd1;
	localparam logic [IDX_W-1:0] CFG_CHECK_MOVE_TENTHS = 2'd2;
	localparam logic [IDX_W-1:0] CFG_FEEDBACK_ENABLE   = 2'd3;

	localparam int TM_WD = 0;
	localparam int TM_EM = 1;
	localparam int TM_CM = 2;

	localparam logic [1:0] MODE_OFF  = 2'd0;
	localparam logic [1:0] MODE_ON   = 2'd1;
	localparam logic [1:0] MODE_SLOW = 2'd2;
	localparam logic [1:0] MODE_FAST = 2'd3;

	localparam logic [1:0] REP_NONE  = 2'd0;
	localparam logic [1:0] REP_SET   = 2'd1;
	localparam logic [1:0] REP_CLEAR = 2'd2;

	localparam logic [3:0] NIB_NONE   = 4'h0;
	localparam logic [3:0] NIB_LOCAL  = 4'h1;
	localparam logic [3:0] NIB_REMOTE = 4'h2;
	localparam logic [3:0] NIB_PUSHED = 4'h4;
	localparam logic [3:0] NIB_RELAY  = 4'h8;

	typedef enum logic [3:0] {
		ST_STARTUP  = 4'd0,
		ST_LOCAL    = 4'd1,
		ST_LPUSHED  = 4'd2,
		ST_REMOTE   = 4'd3,
		ST_WSTOP    = 4'd4,
		ST_WRELAY   = 4'd5,
		ST_PCWAIT   = 4'd6,
		ST_RSTOP    = 4'd7,
		ST_RRELAY   = 4'd8,
		ST_RSTOPPED = 4'd9
	} state_t;

	typedef struct packed {
		logic ms_tick;
		logic reset_msg;
		logic watchdog_msg;
		logic emergency_push;
		logic move_seen;
	} in_word_t;

	typedef struct packed {
		logic [3:0] state_code;
		logic       relay_closed;
		logic       yellow_led;
		logic       green_led;
		logic       red_led;
		logic [1:0] safety_led_mode;
		logic [1:0] emergency_report;
		logic       feedback_valid;
		logic [3:0] feedback_nibble;
	} out_word_t;

	typedef struct packed {
		logic [WD_W-1:0] wd_run;
		logic [EM_W-1:0] em_run;
		logic [CM_W-1:0] cm_run;
		logic            fb_en;
	} cfg_t;

	function automatic logic [3:0] fb_nibble(input state_t st);
		logic [3:0] nib;
		unique case (st)
			ST_LOCAL:  nib = NIB_LOCAL;
			ST_REMOTE: nib = NIB_REMOTE;
			ST_LPUSHED: nib = NIB_PUSHED;
			ST_RRELAY: nib = NIB_RELAY;
			default:   nib = NIB_NONE;
		endcase
		return nib;
	endfunction

endpackage

// ===== rtl/sweif_cfg.sv =====
// Configuration registers, stored as run times in milliseconds.
// Depends on sweif_pkg.
module sweif_cfg
	import sweif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wd_run <= WD_W'(32'(WD_RESET_SECONDS) * MS_PER_SECOND);
			cfg_q.em_run <= EM_W'(32'(EM_RESET_TENTHS) * MS_PER_TENTH);
			cfg_q.cm_run <= CM_W'(32'(CM_RESET_TENTHS) * MS_PER_TENTH);
			cfg_q.fb_en  <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_WATCHDOG_SECONDS:  cfg_q.wd_run <= WD_W'(32'(cfg_data) * MS_PER_SECOND);
				CFG_EMERGENCY_TENTHS:  cfg_q.em_run <= EM_W'(32'(cfg_data) * MS_PER_TENTH);
				CFG_CHECK_MOVE_TENTHS: cfg_q.cm_run <= CM_W'(32'(cfg_data) * MS_PER_TENTH);
				CFG_FEEDBACK_ENABLE:   cfg_q.fb_en  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/sweif_core.sv =====
// Interlock state machine, timers and output latches; one word per step.
// Depends on sweif_pkg.
module sweif_core
	import sweif_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_word_t  item,
	input  cfg_t      cfg,
	output out_word_t res
);

	state_t          state_q, cur_c, nxt_c;
	logic [WD_W-1:0] wd_cnt_q, wd_c;
	logic [EM_W-1:0] em_cnt_q, em_c;
	logic [CM_W-1:0] cm_cnt_q, cm_c;
	logic [2:0]      run_q, run_c;
	logic            move_q, move_c;
	logic [3:0]      last_fb_q, last_fb_c;
	logic            relay_q, relay_c, yel_q, yel_c, grn_q, grn_c, red_q, red_c;
	logic [1:0]      mode_q, mode_c, rep_c;
	logic            fbv_c, wd_exp, em_exp, cm_exp;
	logic [3:0]      fbn_c, nib_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_STARTUP;
			wd_cnt_q  <= '0;
			em_cnt_q  <= '0;
			cm_cnt_q  <= '0;
			run_q     <= '0;
			move_q    <= 1'b0;
			last_fb_q <= NIB_NONE;
			relay_q   <= 1'b0;
			yel_q     <= 1'b0;
			grn_q     <= 1'b0;
			red_q     <= 1'b0;
			mode_q    <= MODE_OFF;
		end else if (step) begin
			state_q   <= nxt_c;
			wd_cnt_q  <= wd_c;
			em_cnt_q  <= em_c;
			cm_cnt_q  <= cm_c;
			run_q     <= run_c;
			move_q    <= move_c;
			last_fb_q <= last_fb_c;
			relay_q   <= relay_c;
			yel_q     <= yel_c;
			grn_q     <= grn_c;
			red_q     <= red_c;
			mode_q    <= mode_c;
		end
	end

	always_comb begin
		wd_c      = wd_cnt_q;
		em_c      = em_cnt_q;
		cm_c      = cm_cnt_q;
		run_c     = run_q;
		move_c    = move_q;
		last_fb_c = last_fb_q;
		relay_c   = relay_q;
		yel_c     = yel_q;
		grn_c     = grn_q;
		red_c     = red_q;
		mode_c    = mode_q;
		rep_c     = REP_NONE;
		fbv_c     = 1'b0;
		fbn_c     = NIB_NONE;

		if (item.ms_tick) begin
			if (run_c[TM_WD] && !(&wd_c)) wd_c = wd_c + WD_W'(1);
			if (run_c[TM_EM] && !(&em_c)) em_c = em_c + EM_W'(1);
			if (run_c[TM_CM] && !(&cm_c)) cm_c = cm_c + CM_W'(1);
		end
		if (item.watchdog_msg) begin
			wd_c         = '0;
			run_c[TM_WD] = 1'b1;
		end
		if (item.move_seen) move_c = 1'b1;

		cur_c = state_q;
		if (item.reset_msg && state_q != ST_STARTUP && state_q != ST_LOCAL &&
				state_q != ST_WRELAY && state_q != ST_RRELAY) begin
			cur_c = ST_STARTUP;
		end

		wd_exp = run_c[TM_WD] && (wd_c >= cfg.wd_run);
		em_exp = run_c[TM_EM] && (em_c >= cfg.em_run);
		cm_exp = run_c[TM_CM] && (cm_c >= cfg.cm_run);

		nxt_c = cur_c;
		unique case (cur_c)
			ST_STARTUP: begin
				yel_c   = 1'b1;
				grn_c   = 1'b0;
				red_c   = 1'b0;
				mode_c  = MODE_ON;
				relay_c = 1'b1;
				rep_c   = REP_CLEAR;
				nxt_c   = ST_LOCAL;
			end
			ST_LOCAL: begin
				if (item.watchdog_msg) begin
					yel_c = 1'b0;
					grn_c = 1'b1;
					nxt_c = ST_REMOTE;
				end else if (item.emergency_push) begin
					relay_c = 1'b0;
					red_c   = 1'b1;
					mode_c  = MODE_SLOW;
					rep_c   = REP_SET;
					nxt_c   = ST_LPUSHED;
				end
			end
			ST_LPUSHED, ST_WRELAY, ST_RRELAY: begin
				if (item.emergency_push) nxt_c = ST_STARTUP;
			end
			ST_REMOTE: begin
				if (item.watchdog_msg) begin
				end else if (wd_exp) begin
					run_c[TM_WD] = 1'b0;
					grn_c        = 1'b0;
					red_c        = 1'b1;
					cm_c         = '0;
					run_c[TM_CM] = 1'b1;
					move_c       = 1'b0;
					nxt_c        = ST_WSTOP;
				end else if (item.emergency_push) begin
					mode_c       = MODE_SLOW;
					rep_c        = REP_SET;
					em_c         = '0;
					run_c[TM_EM] = 1'b1;
					nxt_c        = ST_PCWAIT;
				end
			end
			ST_WSTOP: begin
				if (move_c) begin
					relay_c = 1'b0;
					mode_c  = MODE_FAST;
					nxt_c   = ST_WRELAY;
				end else if (cm_exp) begin
					run_c[TM_CM] = 1'b0;
					nxt_c        = ST_STARTUP;
				end
			end
			ST_PCWAIT: begin
				if (em_exp) begin
					run_c[TM_EM] = 1'b0;
					grn_c        = 1'b0;
					red_c        = 1'b1;
					cm_c         = '0;
					run_c[TM_CM] = 1'b1;
					move_c       = 1'b0;
					nxt_c        = ST_RSTOP;
				end
			end
			ST_RSTOP: begin
				if (move_c) begin
					relay_c = 1'b0;
					mode_c  = MODE_FAST;
					nxt_c   = ST_RRELAY;
				end else if (cm_exp) begin
					run_c[TM_CM] = 1'b0;
					nxt_c        = ST_RSTOPPED;
				end
			end
			ST_RSTOPPED: begin
				if (item.emergency_push || move_c) nxt_c = ST_STARTUP;
			end
			default: ;
		endcase

		// report the new state only when it differs from the last one sent
		nib_c = fb_nibble(nxt_c);
		if (nxt_c != cur_c && nib_c != NIB_NONE && cfg.fb_en && nib_c != last_fb_q) begin
			last_fb_c = nib_c;
			fbv_c     = 1'b1;
			fbn_c     = nib_c;
		end

		res.state_code       = nxt_c;
		res.relay_closed     = relay_c;
		res.yellow_led       = yel_c;
		res.green_led        = grn_c;
		res.red_led          = red_c;
		res.safety_led_mode  = mode_c;
		res.emergency_report = rep_c;
		res.feedback_valid   = fbv_c;
		res.feedback_nibble  = fbn_c;
	end

	a_pcwait_timer: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PCWAIT |-> run_q[TM_EM])
		else $error("emergency timer stopped while waiting for the PC");

	a_relay_open: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRELAY || state_q == ST_RRELAY) |-> !relay_q)
		else $error("relay closed in a relay-off state");

	a_stop_red: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WSTOP || state_q == ST_RSTOP) |-> (red_q && run_q[TM_CM]))
		else $error("stop state without red LED or movement timer");

	a_fb_step: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.feedback_valid) |=> last_fb_q == $past(res.feedback_nibble))
		else $error("sent feedback nibble not recorded");

endmodule

// ===== rtl/sweif_out_buf.sv =====
// Two-entry result buffer between the state machine and the output channel.
// Depends on sweif_pkg.
module sweif_out_buf
	import sweif_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  out_word_t push_data,
	output logic      full,
	output logic      out_valid,
	input  logic      out_ready,
	output out_word_t out_data
);

	out_word_t  mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign pop       = out_valid && out_ready;
	assign full      = cnt_q == 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full result buffer");

	a_count_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
		else $error("result buffer count and pointers disagree");

	a_held_head: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(out_data))
		else $error("stalled result word changed");

endmodule

// ===== rtl/safety_watchdog_interlock_fsm_unit.sv =====
// Top level of the safety watchdog interlock: input register, state machine,
// configuration registers and result buffer. Depends on sweif_pkg and all sweif_* modules.
//
// Input channel in_valid/in_ready/in_data carries one control-loop pass per word:
// millisecond tick and event flags. Output channel out_valid/out_ready/out_data
// returns exactly one result word per input word, in order: state, relay, LEDs,
// emergency report and a feedback nibble.
// An accepted word is held in the input register until the result buffer has room; it is
// then stepped through the state machine and its result word is written into the buffer.
// Throughput: one word per cycle while out_ready stays high.
// Stall: a two-entry result buffer and the input register absorb three words;
// in_ready drops only while the input register is full and the buffer is full.
// Configuration (cfg_we/cfg_index/cfg_data) must be written while the block is idle;
// the user must keep to this; the block does not enforce it. Reset: startup state,
// timers stopped, relay and LEDs off, buffer empty, configuration at 5 s watchdog, 2.0 s
// emergency, 2.0 s movement watch, feedback enabled.
module safety_watchdog_interlock_fsm_unit
	import sweif_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_word_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_word_t        out_data,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	logic      valid_s1, advance, buf_full;
	in_word_t  item_s1;
	cfg_t      cfg;
	out_word_t res;

	assign advance  = valid_s1 && !buf_full;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) item_s1 <= in_data;
	end

	sweif_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	sweif_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	sweif_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== test/safety_watchdog_interlock_fsm_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for safety_watchdog_interlock_fsm_unit: directed and random
// loop passes, predicted by an in-bench interlock model. Depends on sweif_pkg and the RTL.
module safety_watchdog_interlock_fsm_unit_tb;
	import sweif_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int unsigned WD_CAP = (1 << WD_W) - 1;
	localparam int unsigned EM_CAP = (1 << EM_W) - 1;
	localparam int unsigned CM_CAP = (1 << CM_W) - 1;

	// field order: ms_tick, reset_msg, watchdog_msg, emergency_push, move_seen
	localparam in_word_t W_NONE = 5'b00000;
	localparam in_word_t W_ALL  = 5'b11111;
	localparam in_word_t W_RST  = 5'b01000;
	localparam in_word_t W_WD   = 5'b00100;
	localparam in_word_t W_PUSH = 5'b00010;
	localparam in_word_t W_MOVE = 5'b00001;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	in_word_t         in_data;
	logic             out_valid;
	logic             out_ready;
	out_word_t        out_data;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	out_word_t   pending_results[$];
	int          fail_count = 0;
	int          idle_cycles = 0;
	bit          in_burst = 1'b0;
	bit          out_burst = 1'b0;

	state_t      cur_state = ST_STARTUP;
	int unsigned wd_cnt = 0;
	int unsigned em_cnt = 0;
	int unsigned cm_cnt = 0;
	logic [2:0]  tmr_on = 3'b000;
	logic        moved = 1'b0;
	logic [3:0]  fb_last = NIB_NONE;
	logic        relay = 1'b0;
	logic        led_y = 1'b0;
	logic        led_g = 1'b0;
	logic        led_r = 1'b0;
	logic [1:0]  led_mode = MODE_OFF;
	logic [1:0]  rep;
	logic        fb_v;
	logic [3:0]  fb_nib;
	logic [7:0]  wd_sec = WD_RESET_SECONDS;
	logic [7:0]  em_tenths = EM_RESET_TENTHS;
	logic [7:0]  cm_tenths = CM_RESET_TENTHS;
	logic        fb_en = 1'b1;

	safety_watchdog_interlock_fsm_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int unsigned bump(int unsigned c, int unsigned cap);
		return (c < cap) ? c + 1 : cap;
	endfunction

	function automatic bit timer_done(int idx, int unsigned cnt, int unsigned run);
		if (tmr_on[idx] && cnt >= run) begin
			tmr_on[idx] = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void enter_state(state_t nxt);
		logic [3:0] nib;
		if (nxt == cur_state)
			return;
		cur_state = nxt;
		case (nxt)
			ST_LOCAL:   nib = NIB_LOCAL;
			ST_REMOTE:  nib = NIB_REMOTE;
			ST_LPUSHED: nib = NIB_PUSHED;
			ST_RRELAY:  nib = NIB_RELAY;
			default:    return;
		endcase
		if (fb_en && nib != fb_last) begin
			fb_last = nib;
			fb_v = 1'b1;
			fb_nib = nib;
		end
	endfunction

	function automatic void arm_check_move();
		led_g = 1'b0;
		led_r = 1'b1;
		cm_cnt = 0;
		tmr_on[TM_CM] = 1'b1;
		moved = 1'b0;
	endfunction

	function automatic out_word_t predict_step(in_word_t w);
		out_word_t   r;
		int unsigned wd_run;
		int unsigned em_run;
		int unsigned cm_run;
		wd_run = wd_sec * MS_PER_SECOND;
		em_run = em_tenths * MS_PER_TENTH;
		cm_run = cm_tenths * MS_PER_TENTH;
		rep = REP_NONE;
		fb_v = 1'b0;
		fb_nib = NIB_NONE;
		if (w.ms_tick) begin
			if (tmr_on[TM_WD])
				wd_cnt = bump(wd_cnt, WD_CAP);
			if (tmr_on[TM_EM])
				em_cnt = bump(em_cnt, EM_CAP);
			if (tmr_on[TM_CM])
				cm_cnt = bump(cm_cnt, CM_CAP);
		end
		if (w.watchdog_msg) begin
			wd_cnt = 0;
			tmr_on[TM_WD] = 1'b1;
		end
		if (w.move_seen)
			moved = 1'b1;
		if (w.reset_msg && cur_state != ST_STARTUP && cur_state != ST_LOCAL &&
				cur_state != ST_WRELAY && cur_state != ST_RRELAY)
			enter_state(ST_STARTUP);

		case (cur_state)
			ST_STARTUP: begin
				led_y = 1'b1;
				led_g = 1'b0;
				led_r = 1'b0;
				led_mode = MODE_ON;
				relay = 1'b1;
				rep = REP_CLEAR;
				enter_state(ST_LOCAL);
			end
			ST_LOCAL: begin
				if (w.watchdog_msg) begin
					led_y = 1'b0;
					led_g = 1'b1;
					enter_state(ST_REMOTE);
				end else if (w.emergency_push) begin
					relay = 1'b0;
					led_r = 1'b1;
					led_mode = MODE_SLOW;
					rep = REP_SET;
					enter_state(ST_LPUSHED);
				end
			end
			ST_LPUSHED, ST_WRELAY, ST_RRELAY: begin
				if (w.emergency_push)
					enter_state(ST_STARTUP);
			end
			ST_REMOTE: begin
				if (!w.watchdog_msg) begin
					if (timer_done(TM_WD, wd_cnt, wd_run)) begin
						arm_check_move();
						enter_state(ST_WSTOP);
					end else if (w.emergency_push) begin
						led_mode = MODE_SLOW;
						rep = REP_SET;
						em_cnt = 0;
						tmr_on[TM_EM] = 1'b1;
						enter_state(ST_PCWAIT);
					end
				end
			end
			ST_WSTOP: begin
				if (moved) begin
					relay = 1'b0;
					led_mode = MODE_FAST;
					enter_state(ST_WRELAY);
				end else if (timer_done(TM_CM, cm_cnt, cm_run)) begin
					enter_state(ST_STARTUP);
				end
			end
			ST_PCWAIT: begin
				if (timer_done(TM_EM, em_cnt, em_run)) begin
					arm_check_move();
					enter_state(ST_RSTOP);
				end
			end
			ST_RSTOP: begin
				if (moved) begin
					relay = 1'b0;
					led_mode = MODE_FAST;
					enter_state(ST_RRELAY);
				end else if (timer_done(TM_CM, cm_cnt, cm_run)) begin
					enter_state(ST_RSTOPPED);
				end
			end
			ST_RSTOPPED: begin
				if (w.emergency_push || moved)
					enter_state(ST_STARTUP);
			end
			default: ;
		endcase

		r.state_code = cur_state;
		r.relay_closed = relay;
		r.yellow_led = led_y;
		r.green_led = led_g;
		r.red_led = led_r;
		r.safety_led_mode = led_mode;
		r.emergency_report = rep;
		r.feedback_valid = fb_v;
		r.feedback_nibble = fb_nib;
		return r;
	endfunction

	// drive one word at a falling edge, hold it until taken, then predict
	task automatic send_word(input in_word_t w);
		int gap;
		gap = in_burst ? 0 : $urandom_range(0, 13);
		if ($urandom_range(0, 63) == 0)
			in_burst = !in_burst;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(predict_step(w));
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_WATCHDOG_SECONDS:  wd_sec = data;
			CFG_EMERGENCY_TENTHS:  em_tenths = data;
			CFG_CHECK_MOVE_TENTHS: cm_tenths = data;
			CFG_FEEDBACK_ENABLE:   fb_en = data[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] wd, em, cm, input logic fb);
		wait_idle();
		write_reg(CFG_WATCHDOG_SECONDS, wd);
		write_reg(CFG_EMERGENCY_TENTHS, em);
		write_reg(CFG_CHECK_MOVE_TENTHS, cm);
		write_reg(CFG_FEEDBACK_ENABLE, {7'($urandom_range(0, 127)), fb});
	endtask

	function automatic in_word_t rand_word(int unsigned p_tick, p_rst, p_wd, p_push, p_mv);
		in_word_t w;
		w.ms_tick = $urandom_range(0, 99) < p_tick;
		w.reset_msg = $urandom_range(0, 99) < p_rst;
		w.watchdog_msg = $urandom_range(0, 99) < p_wd;
		w.emergency_push = $urandom_range(0, 99) < p_push;
		w.move_seen = $urandom_range(0, 99) < p_mv;
		return w;
	endfunction

	// hold off halfway until every result is back
	task automatic run_random(input int n, input int unsigned p_tick, p_rst, p_wd, p_push,
			p_mv);
		for (int i = 0; i < n; i++) begin
			if (i == n / 2)
				wait_idle();
			send_word(rand_word(p_tick, p_rst, p_wd, p_push, p_mv));
		end
	endtask

	task automatic go_local();
		while (cur_state != ST_LOCAL) begin
			case (cur_state)
				ST_STARTUP: send_word(W_NONE);
				ST_LPUSHED, ST_WRELAY, ST_RRELAY: send_word(W_PUSH);
				default: send_word(W_RST);
			endcase
		end
	endtask

	task automatic test_local_mode();
		send_word(W_NONE);
		send_word(W_ALL);
		send_word(W_PUSH);
		send_word(W_RST);
		send_word(W_PUSH);
		send_word(W_RST);
		send_word(W_PUSH);
		send_word(W_PUSH);
	endtask

	task automatic test_watchdog_zero_run();
		set_config(8'd0, 8'd0, 8'd0, 1'b1);
		send_word(W_WD);
		send_word(W_NONE);
		send_word(W_NONE);
		send_word(W_NONE);
		send_word(W_WD);
		send_word(W_NONE);
		send_word(W_MOVE);
		send_word(W_RST | W_PUSH);
		send_word(W_NONE);
	endtask

	task automatic test_emergency_path();
		set_config(8'd255, 8'd0, 8'd0, 1'b1);
		send_word(W_WD);
		send_word(W_PUSH);
		send_word(W_NONE);
		send_word(W_NONE);
		send_word(W_MOVE);
		send_word(W_NONE);
		send_word(W_WD);
		send_word(W_PUSH);
		send_word(W_NONE);
		send_word(W_MOVE);
		send_word(W_RST | W_PUSH);
	endtask

	task automatic test_random_zero_timers();
		set_config(8'd0, 8'd0, 8'd0, 1'b1);
		run_random(100, 50, 8, 25, 15, 10);
	endtask

	task automatic test_emergency_timers();
		set_config(8'd255, 8'd1, 8'd1, 1'b0);
		go_local();
		run_random(100, 90, 1, 4, 6, 2);
	endtask

	task automatic test_watchdog_one_second();
		set_config(8'd1, 8'd255, 8'd1, 1'b1);
		go_local();
		send_word(W_WD);
		run_random(1100, 97, 0, 0, 0, 1);
	endtask

	task automatic test_feedback_noise();
		set_config(8'd0, 8'd2, 8'd255, 1'b0);
		run_random(50, 50, 50, 50, 50, 50);
		set_config(8'd0, 8'd0, 8'd0, 1'b1);
		run_random(50, 50, 50, 50, 50, 50);
	endtask

	task automatic check_word(input out_word_t got);
		out_word_t want;
		if (pending_results.size() == 0) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result %h with none expected", $time, got);
			return;
		end
		want = pending_results.pop_front();
		if (got.state_code !== want.state_code || got.relay_closed !== want.relay_closed ||
				got.yellow_led !== want.yellow_led || got.green_led !== want.green_led ||
				got.red_led !== want.red_led ||
				got.safety_led_mode !== want.safety_led_mode ||
				got.emergency_report !== want.emergency_report ||
				got.feedback_valid !== want.feedback_valid ||
				got.feedback_nibble !== want.feedback_nibble) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("%0t: mismatch, expected/actual:", $time);
				$display("  state %0d/%0d relay %b/%b yellow %b/%b green %b/%b red %b/%b",
					want.state_code, got.state_code, want.relay_closed, got.relay_closed,
					want.yellow_led, got.yellow_led, want.green_led, got.green_led,
					want.red_led, got.red_led);
				$display("  mode %0d/%0d report %0d/%0d feedback %b:%h/%b:%h",
					want.safety_led_mode, got.safety_led_mode, want.emergency_report,
					got.emergency_report, want.feedback_valid, want.feedback_nibble,
					got.feedback_valid, got.feedback_nibble);
			end
		end
	endtask

	initial begin
		int gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			gap = out_burst ? 0 : $urandom_range(0, 13);
			if ($urandom_range(0, 63) == 0)
				out_burst = !out_burst;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			check_word(out_data);
			@(negedge clk);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = W_NONE;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_local_mode();
		test_watchdog_zero_run();
		test_emergency_path();
		test_random_zero_timers();
		test_emergency_timers();
		test_watchdog_one_second();
		test_feedback_noise();
		wait_idle();
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
